// ===== sv/sha1_message_hasher_top_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-1 hasher assertion macros
// Short forms for the concurrent checks used on the hasher ports.
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_HASHER_TOP_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_TOP_DEFINES_SVH

// Condition must never hold outside reset
`define SHA1_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define SHA1_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SHA1_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Types, constants and round helpers shared by the hasher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1_pkg;

    // Round working registers a..e
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1_work_t;

    // Chaining words, index 0 is A
    typedef logic [4:0][31:0] sha1_hash_t;

    // Sixteen schedule words, newest in the low word, oldest in the top word
    typedef logic [511:0] sha1_sched_t;

    typedef logic [6:0] sha1_round_t;
    typedef logic [1:0] sha1_phase_t;

    localparam sha1_hash_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                      32'hEFCDAB89, 32'h67452301};

    localparam sha1_round_t ROUND_LAST     = 7'd79;
    localparam sha1_round_t ROUND_SCHED    = 7'd16;
    localparam sha1_round_t ROUND_PHASE1   = 7'd20;
    localparam sha1_round_t ROUND_PHASE2   = 7'd40;
    localparam sha1_round_t ROUND_PHASE3   = 7'd60;

    localparam sha1_phase_t PHASE_CH     = 2'd0;
    localparam sha1_phase_t PHASE_PAR_LO = 2'd1;
    localparam sha1_phase_t PHASE_MAJ    = 2'd2;
    localparam sha1_phase_t PHASE_PAR_HI = 2'd3;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] MARK_LAST = 6'd55;
    localparam logic [5:0] BYTE_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST = 3'd4;

    // Round constant for each group of twenty rounds
    function automatic logic [31:0] sha1_k(input sha1_phase_t phase);
        logic [31:0] k;
        unique case (phase)
            PHASE_CH:     k = 32'h5A827999;
            PHASE_PAR_LO: k = 32'h6ED9EBA1;
            PHASE_MAJ:    k = 32'h8F1BBCDC;
            default:      k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/sha1_in_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message channel
// Valid/ready channel carrying one message byte with its flags per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;

    modport source (output valid, data_byte, byte_valid, message_end, input ready);
    modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

// ===== sv/sha1_out_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 digest channel
// Valid/ready channel carrying one 32-bit digest word per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha1_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round: schedule expansion, round function and the
// five-way sum, shared by all eighty rounds of a block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_round
    import sha1_pkg::*;
(
    input  sha1_round_t round_idx,
    input  sha1_work_t  work,
    input  sha1_sched_t sched,
    output sha1_work_t  work_upd,
    output logic [31:0] sched_word
);

    sha1_phase_t phase;
    logic [31:0] w_mix;
    logic [31:0] w_exp;
    logic [31:0] f_val;
    logic [31:0] sum;

    // Pick the round group
    always_comb
    begin
        priority if (round_idx < ROUND_PHASE1)
            phase = PHASE_CH;
        else if (round_idx < ROUND_PHASE2)
            phase = PHASE_PAR_LO;
        else if (round_idx < ROUND_PHASE3)
            phase = PHASE_MAJ;
        else
            phase = PHASE_PAR_HI;
    end

    // Expand the schedule from words t-3, t-8, t-14 and t-16
    assign w_mix = sched[95:64] ^ sched[255:224] ^ sched[447:416] ^ sched[511:480];
    assign w_exp = {w_mix[30:0], w_mix[31]};
    assign sched_word = (round_idx < ROUND_SCHED) ? sched[511:480] : w_exp;

    // Round function
    always_comb
    begin
        unique case (phase)
            PHASE_CH:  f_val = (work.b & work.c) | (~work.b & work.d);
            PHASE_MAJ: f_val = (work.b & work.c) | (work.b & work.d) | (work.c & work.d);
            default:   f_val = work.b ^ work.c ^ work.d;
        endcase
    end

    assign sum = {work.a[26:0], work.a[31:27]} + f_val + work.e + sched_word + sha1_k(phase);

    // Shift the working words along
    assign work_upd.a = sum;
    assign work_upd.b = work.a;
    assign work_upd.c = {work.b[1:0], work.b[31:2]};
    assign work_upd.d = work.c;
    assign work_upd.e = work.d;

endmodule

// ===== sv/sha1_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message hasher
// Byte-serial SHA-1 with a single shared round unit and a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : one word per message byte (data_byte, byte_valid) and a
//            message_end flag; a word with neither flag set does nothing.
//   digest : five words A..E per message, word_index 0..4, last_word on E.
// Flow:
//   Bytes that do not complete a block are taken one per cycle, as long
//   as msg.ready is high. A completed 64-byte block runs 80 rounds through
//   the one round unit, then is added into the chaining words.
//   On message_end the pad, zero fill and length bytes enter one per cycle,
//   then each padded block is compressed; a second block follows when 56
//   or more bytes were pending. msg.ready is low for all of this and while
//   digest words are pending.
// Reset: chaining words load the initial value, counts clear, the block
//   is ready in the first cycle after rst_n rises.
// Stall: a digest word holds until digest.ready; nothing else advances.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_hasher_top
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sha1_in_if.sink    msg,
    sha1_out_if.source digest
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [60:0] len_reg, len_next;
    sha1_round_t rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic        fin_reg, fin_next;
    logic        mark_reg, mark_next;
    logic        len_ok_reg, len_ok_next;
    sha1_hash_t  hash_reg, hash_next;
    sha1_sched_t sched_reg, sched_next;
    sha1_work_t  work_reg, work_next;

    sha1_work_t  round_work;
    logic [31:0] round_word;
    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;

    sha1_round u_round (
        .round_idx  (rnd_reg),
        .work       (work_reg),
        .sched      (sched_reg),
        .work_upd   (round_work),
        .sched_word (round_word)
    );

    // Select the big-endian length byte for buffer positions 56..63
    assign len_bits = {len_reg, 3'b000};
    assign len_byte = len_bits[{~cnt_reg[2:0], 3'b000} +: 8];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        fin_next    = fin_reg;
        mark_next   = mark_reg;
        len_ok_next = len_ok_reg;
        hash_next   = hash_reg;
        work_next   = work_reg;
        shift_en    = 1'b0;
        shift_byte  = 8'h00;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.byte_valid)
                    begin
                        shift_en   = 1'b1;
                        shift_byte = msg.data_byte;
                        cnt_next   = cnt_reg + 6'd1;
                        len_next   = len_reg + 61'd1;
                    end
                    if (msg.message_end)
                        fin_next = 1'b1;
                    if (msg.byte_valid && (cnt_reg == BYTE_LAST))
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                        work_next  = '{a: hash_reg[0], b: hash_reg[1], c: hash_reg[2],
                                       d: hash_reg[3], e: hash_reg[4]};
                    end
                    else if (msg.message_end)
                        state_next = ST_PAD;
                end
            end

            ST_PAD:
            begin
                shift_en = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (!mark_reg)
                begin
                    shift_byte = PAD_MARK;
                    mark_next  = 1'b1;
                    if (cnt_reg <= MARK_LAST)
                        len_ok_next = 1'b1;
                end
                else if (len_ok_reg && (cnt_reg >= LEN_START))
                    shift_byte = len_byte;
                else
                    shift_byte = 8'h00;
                if (cnt_reg == BYTE_LAST)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    work_next  = '{a: hash_reg[0], b: hash_reg[1], c: hash_reg[2],
                                   d: hash_reg[3], e: hash_reg[4]};
                end
            end

            ST_ROUND:
            begin
                work_next = round_work;
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == ROUND_LAST)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                hash_next[0] = hash_reg[0] + work_reg.a;
                hash_next[1] = hash_reg[1] + work_reg.b;
                hash_next[2] = hash_reg[2] + work_reg.c;
                hash_next[3] = hash_reg[3] + work_reg.d;
                hash_next[4] = hash_reg[4] + work_reg.e;
                priority if (!fin_reg)
                    state_next = ST_IDLE;
                else if (len_ok_reg)
                begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end
                else
                begin
                    // Overflow block done: the length goes in the next one
                    len_ok_next = 1'b1;
                    state_next  = ST_PAD;
                end
            end

            ST_OUT:
            begin
                if (digest.ready)
                begin
                    idx_next  = idx_reg + 3'd1;
                    hash_next = {hash_reg[0], hash_reg[4:1]};
                    if (idx_reg == WORD_LAST)
                    begin
                        hash_next   = SHA1_IV;
                        len_next    = '0;
                        idx_next    = '0;
                        fin_next    = 1'b0;
                        mark_next   = 1'b0;
                        len_ok_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shift bytes in, or roll the schedule during rounds
    always_comb
    begin
        sched_next = sched_reg;
        if (shift_en)
            sched_next = {sched_reg[503:0], shift_byte};
        else if (state_reg == ST_ROUND)
            sched_next = {sched_reg[479:0], round_word};
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            len_reg    <= '0;
            rnd_reg    <= '0;
            idx_reg    <= '0;
            fin_reg    <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            hash_reg   <= SHA1_IV;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            fin_reg    <= fin_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
            hash_reg   <= hash_next;
        end
    end

    // Block buffer, schedule and working words
    always_ff @(posedge clk)
    begin
        sched_reg <= sched_next;
        work_reg  <= work_next;
    end

    // Ports
    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = hash_reg[0];
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = (idx_reg == WORD_LAST);

endmodule

// ===== sv/sha1_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher port checker
// Checks sequencing of the message and digest channels seen at the ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha1_message_hasher_top_defines.svh"

module sha1_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       msg_message_end,
    input logic       digest_valid,
    input logic       digest_ready,
    input logic [2:0] digest_word_index,
    input logic       digest_last_word
);

    logic       end_take;
    logic       word_take;
    logic       index_ok;
    logic       index_step_ok;
    logic [2:0] prev_index_reg;

    // Handshake and index conditions
    assign end_take      = msg_valid && msg_ready && msg_message_end;
    assign word_take     = digest_valid && digest_ready;
    assign index_ok      = (digest_word_index <= 3'd4) &&
                           (digest_last_word == (digest_word_index == 3'd4));
    assign index_step_ok = digest_valid && (digest_word_index == prev_index_reg + 3'd1);

    // Hold the index seen at the previous edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_index_reg <= '0;
        else
            prev_index_reg <= digest_word_index;
    end

    // Never take message bytes while a digest is being delivered
    `SHA1_ASSERT_NEVER(a_no_overlap, digest_valid && msg_ready, "ready while digest pending")

    // Word index in range and last flag only on E
    `SHA1_ASSERT_IMP(a_index_ok, digest_valid, index_ok, "bad digest word index")

    // Digest words advance one by one
    `SHA1_ASSERT_NXT(a_index_step, word_take && !digest_last_word, index_step_ok, "word skipped")

    // End of message stops intake until the digest is out
    `SHA1_ASSERT_NXT(a_end_busy, end_take, !msg_ready, "ready right after message end")

    // Last digest word frees the input
    `SHA1_ASSERT_NXT(a_free_after, word_take && digest_last_word, msg_ready, "not ready at end")

endmodule

bind sha1_message_hasher_top sha1_checker u_sha1_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .msg_valid         (msg.valid),
    .msg_ready         (msg.ready),
    .msg_message_end   (msg.message_end),
    .digest_valid      (digest.valid),
    .digest_ready      (digest.ready),
    .digest_word_index (digest.word_index),
    .digest_last_word  (digest.last_word)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// SHA-1 message hasher testbench
// Feeds byte streams into the hasher and predicts each message digest with a
// local SHA-1 model. Every digest word is checked against the prediction.
// Both channels idle at random, and one phase holds the digest side off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF         = 4;
    localparam int RESET_CYCLES     = 9;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int DRAIN_CYCLES     = 320;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_WORDS     = 100;

    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;
    localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                           32'h10325476, 32'hC3D2E1F0};
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam int          BLOCK_BYTES = 64;
    localparam int          LEN_OFFSET  = 56;
    localparam logic [2:0]  LAST_INDEX  = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_item_t;

    logic clk = 1'b0;
    logic rst_n;

    sha1_in_if  msg_if ();
    sha1_out_if digest_if ();

    sha1_message_hasher_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_if),
        .digest (digest_if)
    );

    // Local hash state
    logic [31:0]  hash_chain [5];
    logic [7:0]   block_bytes [BLOCK_BYTES];
    int           block_fill;
    logic [60:0]  message_bytes;
    digest_item_t digest_expect_q [$];

    int  fail_count;
    int  cycle_count;
    bit  src_idle_on;
    bit  sink_idle_on;
    bit  long_hold_on;
    event digest_hold_go;

    // Clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Run the 80 rounds over the current block and fold into the chain
    function automatic void fold_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
            w[t] = {block_bytes[4 * t], block_bytes[4 * t + 1],
                    block_bytes[4 * t + 2], block_bytes[4 * t + 3]};
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t >= 16)
            begin
                tmp = w[(t - 3) % 16] ^ w[(t - 8) % 16] ^ w[(t - 14) % 16] ^ w[t % 16];
                w[t % 16] = {tmp[30:0], tmp[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_ROUND0;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K_ROUND1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUND2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_ROUND3;
            end
            tmp = {a[26:0], a[31:27]} + f + e + w[t % 16] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    function automatic void clear_hash();
        for (int i = 0; i < 5; i++)
            hash_chain[i] = H_INIT[i];
        block_fill    = 0;
        message_bytes = '0;
    endfunction

    // Advance the local hash by one accepted word; queue the digest on end
    function automatic void hash_accept(input logic [7:0] data, input logic has_byte,
                                        input logic is_end);
        logic [63:0] bit_len;
        if (has_byte)
        begin
            block_bytes[block_fill] = data;
            block_fill++;
            message_bytes = message_bytes + 61'd1;
            if (block_fill == BLOCK_BYTES)
            begin
                fold_block();
                block_fill = 0;
            end
        end
        if (!is_end)
            return;
        block_bytes[block_fill] = PAD_BYTE;
        block_fill++;
        // No room for the length: pad out and spill into a second block
        if (block_fill > LEN_OFFSET)
        begin
            while (block_fill < BLOCK_BYTES)
            begin
                block_bytes[block_fill] = 8'h00;
                block_fill++;
            end
            fold_block();
            block_fill = 0;
        end
        while (block_fill < LEN_OFFSET)
        begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
        end
        bit_len = {message_bytes, 3'b000};
        for (int i = 0; i < 8; i++)
            block_bytes[LEN_OFFSET + i] = bit_len[63 - 8 * i -: 8];
        fold_block();
        for (int i = 0; i < 5; i++)
            digest_expect_q.push_back('{hash_chain[i], 3'(i), 3'(i) == LAST_INDEX});
        clear_hash();
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_cycles(input bit enabled);
        int roll;
        if (!enabled)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input logic [7:0] data, input logic has_byte,
                             input logic is_end);
        int gap;
        gap = idle_cycles(src_idle_on);
        @(negedge clk);
        if (gap > 0)
        begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_if.valid       <= 1'b1;
        msg_if.data_byte   <= data;
        msg_if.byte_valid  <= has_byte;
        msg_if.message_end <= is_end;
        do
            @(posedge clk);
        while (!msg_if.ready);
        hash_accept(data, has_byte, is_end);
    endtask

    task automatic send_message(input int msg_len, input bit end_on_byte,
                                inout int word_total);
        for (int i = 0; i < msg_len; i++)
        begin
            // Drop an empty word in now and then
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, end_on_byte && (i == msg_len - 1));
            word_total++;
        end
        if (!end_on_byte || msg_len == 0)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
            word_total++;
        end
    endtask

    // Digest side ready: random stalls, or a long hold when asked
    initial
    begin
        int stall_left;
        stall_left = 0;
        digest_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_on)
                digest_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                digest_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = idle_cycles(sink_idle_on);
                digest_if.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Long hold on the digest side, counted in cycles
    initial
    begin
        long_hold_on = 1'b0;
        forever
        begin
            @(digest_hold_go);
            long_hold_on = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clk);
            long_hold_on = 1'b0;
        end
    end

    // Check each digest word against the oldest prediction
    always @(posedge clk)
    begin
        digest_item_t got;
        digest_item_t want;
        if (rst_n && digest_if.valid && digest_if.ready)
        begin
            got = '{digest_if.digest_word, digest_if.word_index, digest_if.last_word};
            if (digest_expect_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected digest word %h index %0d last %b",
                             $realtime, got.word, got.index, got.is_last);
            end
            else
            begin
                want = digest_expect_q.pop_front();
                if (got.word !== want.word || got.index !== want.index ||
                    got.is_last !== want.is_last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                 $realtime, want.word, want.index, want.is_last,
                                 got.word, got.index, got.is_last);
                end
            end
        end
    end

    // Empty message: end word with no bytes
    task automatic test_empty_message();
        int words;
        words = 0;
        send_message(0, 1'b0, words);
    endtask

    // Last byte and end in the same word
    task automatic test_byte_with_end();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
    endtask

    // Byte extremes, empty words in between, then an end word alone
    task automatic test_empty_words();
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h5A, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b1);
    endtask

    // Hold the digest side off while the sender keeps offering bytes
    task automatic test_digest_backpressure();
        int words;
        words = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        -> digest_hold_go;
        send_message(9, 1'b1, words);
        send_message(12, 1'b0, words);
        send_message(5, 1'b1, words);
    endtask

    // Random messages, boundary lengths first
    task automatic test_random_messages();
        int word_total;
        int msg_count;
        int msg_len;
        bit end_on_byte;
        word_total = 0;
        msg_count  = 0;
        while (word_total < RANDOM_WORDS)
        begin
            case (msg_count)
                0:       msg_len = BLOCK_BYTES;
                1:       msg_len = $urandom_range(0, 2) == 0 ? 55 :
                                   ($urandom_range(0, 1) == 0 ? 56 : 63);
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        msg_len = $urandom_range(55, 64);
                    else
                        msg_len = $urandom_range(0, 10);
                end
            endcase
            end_on_byte  = (msg_count == 0) || ($urandom_range(0, 1) == 1);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            send_message(msg_len, end_on_byte, word_total);
            msg_count++;
        end
    endtask

    // Main sequence
    initial
    begin
        fail_count   = 0;
        cycle_count  = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        clear_hash();
        rst_n              = 1'b0;
        msg_if.valid       = 1'b0;
        msg_if.data_byte   = 8'h00;
        msg_if.byte_valid  = 1'b0;
        msg_if.message_end = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_message();
        test_byte_with_end();
        test_empty_words();
        test_digest_backpressure();
        test_random_messages();

        @(negedge clk);
        msg_if.valid <= 1'b0;
        while (digest_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
